>>> hw/rtl/gmcd_pkg.sv
`timescale 1ns / 1ps

package gmcd_pkg;

    localparam int ENTRIES_DEFAULT = 128;

    localparam int CODE_W  = 21;
    localparam int DIM_W   = 8;
    localparam int SLOT_W  = 7;
    localparam int COUNT_W = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } tag_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] valid_entries;
    } res_t;

endpackage

>>> hw/rtl/gmcd_tag_ram.sv
`timescale 1ns / 1ps

module gmcd_tag_ram #(
    parameter int ENTRIES = gmcd_pkg::ENTRIES_DEFAULT,
    parameter int ADDR_W  = $clog2(ENTRIES)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  gmcd_pkg::tag_t      wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output gmcd_pkg::tag_t      rd_data
);

    gmcd_pkg::tag_t mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/gmcd_ctrl.sv
`timescale 1ns / 1ps

module gmcd_ctrl #(
    parameter int ENTRIES = gmcd_pkg::ENTRIES_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gmcd_pkg::tag_t in_key,
    input  logic           in_full,
    output logic           res_valid,
    input  logic           res_ready,
    output gmcd_pkg::res_t res
);

    localparam int PTR_W = $clog2(ENTRIES);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] PTR_LAST = CNT_W'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    gmcd_pkg::tag_t   key_reg, key_next;
    logic             full_reg, full_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;
    logic [PTR_W-1:0] slot_reg, slot_next;

    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    gmcd_pkg::tag_t   rd_data;

    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] ptr_ext;
    logic [PTR_W+gmcd_pkg::SLOT_W-1:0]  slot_wide;
    logic [CNT_W+gmcd_pkg::COUNT_W-1:0] cnt_wide;

    assign idx_ext = {1'b0, idx_reg};
    assign ptr_ext = {1'b0, ptr_reg};

    gmcd_tag_ram #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (PTR_W)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        full_next  = full_reg;
        idx_next   = idx_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        slot_next  = slot_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg + PTR_W'(1);
        wr_en      = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    key_next  = in_key;
                    full_next = in_full;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    if (in_full && (cnt_reg != '0)) begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_data == key_reg) begin
                    hit_next   = 1'b1;
                    slot_next  = idx_reg;
                    state_next = ST_DONE;
                end else if ((idx_ext + CNT_W'(1)) == cnt_reg) begin
                    state_next = ST_WRITE;
                end else begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + PTR_W'(1);
                end
            end
            ST_WRITE: begin
                wr_en     = 1'b1;
                hit_next  = 1'b0;
                slot_next = ptr_reg;
                if (full_reg) begin
                    if (ptr_ext >= cnt_reg) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (ptr_ext == PTR_LAST) begin
                        ptr_next = '0;
                    end else begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        full_reg <= full_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        slot_reg <= slot_next;
    end

    assign slot_wide = {{gmcd_pkg::SLOT_W{1'b0}}, slot_reg};
    assign cnt_wide  = {{gmcd_pkg::COUNT_W{1'b0}}, cnt_reg};

    assign res.hit           = hit_reg;
    assign res.slot          = slot_wide[gmcd_pkg::SLOT_W-1:0];
    assign res.valid_entries = cnt_wide[gmcd_pkg::COUNT_W-1:0];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("Valid count exceeds the entry count.");

    a_ptr_tracks_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != CNT_MAX) |-> (ptr_ext == cnt_reg))
        else $error("Fill pointer and valid count diverged before saturation.");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_ext < cnt_reg))
        else $error("Scan index beyond the searchable entries.");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !rd_en)
        else $error("Tag memory read and written in the same cycle.");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && hit_reg) |-> ({1'b0, slot_reg} < cnt_reg))
        else $error("Hit reported on an entry that is not searchable.");
`endif

endmodule

>>> hw/rtl/glyph_mask_cache_directory.sv
`timescale 1ns / 1ps

// Channel | Direction | Contents of tdata, lowest bit first
// s_      | in        | char_code, glyph_width, glyph_height, full_opacity
// m_      | out       | hit, slot, valid_entries
//
// A full-opacity request scans the valid entries in index order, one tag a cycle, and
// stops at the first hit; on a miss it writes the tag at the fill pointer. Any other
// request writes there without a scan. One request is worked on at a time.
// Reset empties the directory at once; no clearing pass follows.
// One result waiting on m_tready does not hold off the next input; a second one does.

module glyph_mask_cache_directory #(
    parameter int ENTRIES = gmcd_pkg::ENTRIES_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // char_code[20:0], glyph_width[28:21], glyph_height[36:29], full_opacity[37]
    input  logic [gmcd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit[0], slot[7:1], valid_entries[15:8]
    output logic [gmcd_pkg::M_TDATA_W-1:0]   m_tdata
);

    gmcd_pkg::tag_t in_key;
    gmcd_pkg::res_t res;
    logic           res_valid;
    logic           res_ready;
    logic           out_valid_reg;
    gmcd_pkg::res_t out_res_reg;

    assign in_key.code   = s_tdata[20:0];
    assign in_key.width  = s_tdata[28:21];
    assign in_key.height = s_tdata[36:29];

    gmcd_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_key    (in_key),
        .in_full   (s_tdata[37]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.valid_entries, out_res_reg.slot, out_res_reg.hit};

endmodule

>>> sim/glyph_mask_cache_directory_tb.sv
`timescale 1ns / 1ps

module glyph_mask_cache_directory_tb;

    localparam int ENTRIES        = gmcd_pkg::ENTRIES_DEFAULT;
    localparam int RANDOM_ITEMS   = 780;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int TAIL_CYCLES    = ENTRIES + 8;
    localparam logic [gmcd_pkg::CODE_W-1:0] CODE_MAX = 21'h10FFFF;

    typedef struct {
        gmcd_pkg::tag_t key;
        logic           full;
    } glyph_req_t;

    typedef struct {
        logic                         hit;
        logic [gmcd_pkg::SLOT_W-1:0]  slot;
        logic [gmcd_pkg::COUNT_W-1:0] count;
    } lookup_res_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gmcd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gmcd_pkg::M_TDATA_W-1:0] m_tdata;

    glyph_req_t     pending_reqs[$];
    gmcd_pkg::tag_t sent_keys[$];
    lookup_res_t    expected_results[$];

    gmcd_pkg::tag_t dir_tag[ENTRIES];
    logic           dir_valid[ENTRIES];
    int   fill_ptr     = 0;
    int   search_count = 0;

    int accepted_in  = 0;
    int idle_cycles  = 0;
    int errors       = 0;
    int hit_count    = 0;
    int miss_count   = 0;
    int partial_count = 0;
    int wrap_count   = 0;
    int tx_gap       = 0;
    int rx_gap       = 0;
    logic hold_rx    = 1'b0;

    glyph_mask_cache_directory #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Mirrors the directory: a FIFO-replaced tag store searched in index order.
    function automatic lookup_res_t directory_lookup(glyph_req_t req);
        lookup_res_t res;
        res.hit  = 1'b0;
        res.slot = '0;
        if (req.full) begin
            for (int i = 0; i < search_count && i < ENTRIES && !res.hit; i++) begin
                if (dir_valid[i] && dir_tag[i] == req.key) begin
                    res.hit  = 1'b1;
                    res.slot = i[gmcd_pkg::SLOT_W-1:0];
                end
            end
        end
        if (!res.hit) begin
            dir_tag[fill_ptr]   = req.key;
            dir_valid[fill_ptr] = 1'b1;
            res.slot            = fill_ptr[gmcd_pkg::SLOT_W-1:0];
            if (req.full) begin
                if (fill_ptr >= search_count && search_count < ENTRIES)
                    search_count++;
                fill_ptr = (fill_ptr + 1) % ENTRIES;
                if (fill_ptr == 0)
                    wrap_count++;
            end
        end
        if (res.hit)
            hit_count++;
        else if (req.full)
            miss_count++;
        else
            partial_count++;
        res.count = search_count[gmcd_pkg::COUNT_W-1:0];
        return res;
    endfunction

    function automatic bit idling_allowed();
        return pending_reqs.size() >= 100 && (accepted_in / 64) % 3 != 2;
    endfunction

    function automatic gmcd_pkg::tag_t random_glyph_key();
        gmcd_pkg::tag_t key;
        int unsigned    r;
        r = $urandom_range(0, CODE_MAX);
        case ($urandom_range(0, 7))
            0: key.code = '0;
            1: key.code = CODE_MAX;
            default: key.code = r[gmcd_pkg::CODE_W-1:0];
        endcase
        r = $urandom_range(0, 255);
        key.width  = ($urandom_range(0, 9) == 0) ? 8'hFF : r[gmcd_pkg::DIM_W-1:0];
        r = $urandom_range(0, 255);
        key.height = ($urandom_range(0, 9) == 0) ? 8'h00 : r[gmcd_pkg::DIM_W-1:0];
        return key;
    endfunction

    task automatic queue_request(logic [gmcd_pkg::CODE_W-1:0] code,
                                 logic [gmcd_pkg::DIM_W-1:0] w,
                                 logic [gmcd_pkg::DIM_W-1:0] h, logic full);
        glyph_req_t req;
        req.key.code   = code;
        req.key.width  = w;
        req.key.height = h;
        req.full       = full;
        pending_reqs.push_back(req);
        sent_keys.push_back(req.key);
    endtask

    always @(posedge aclk) begin : request_driver
        glyph_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= $urandom_range(0, 14);
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                s_tdata  <= {2'b00, nxt.full, nxt.key.height, nxt.key.width, nxt.key.code};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (rx_gap != 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : transfer_monitor
        glyph_req_t  req;
        lookup_res_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                req.key.code   = s_tdata[20:0];
                req.key.width  = s_tdata[28:21];
                req.key.height = s_tdata[36:29];
                req.full       = s_tdata[37];
                expected_results.push_back(directory_lookup(req));
                accepted_in++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding: tdata %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.hit) begin
                        $error("hit mismatch: expected %0d, got %0d", want.hit, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[7:1] !== want.slot) begin
                        $error("slot mismatch: expected %0d, got %0d", want.slot, m_tdata[7:1]);
                        errors++;
                    end
                    if (m_tdata[15:8] !== want.count) begin
                        $error("valid_entries mismatch: expected %0d, got %0d",
                               want.count, m_tdata[15:8]);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver stops for a long stretch while requests keep coming, so
    // that the block backs up and holds off its input.
    initial begin
        wait (accepted_in >= 250);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    initial begin
        gmcd_pkg::tag_t key;
        int   span;
        int   pick;
        int   sel;

        for (int i = 0; i < ENTRIES; i++)
            dir_valid[i] = 1'b0;

        queue_request(21'h0, 8'h00, 8'h00, 1'b1);
        queue_request(21'h0, 8'h00, 8'h00, 1'b1);
        queue_request(CODE_MAX, 8'hFF, 8'hFF, 1'b1);
        queue_request(CODE_MAX, 8'hFF, 8'hFF, 1'b1);
        // A partial-opacity write leaves the pointer, so the next miss lands on the same entry.
        queue_request(21'h01234, 8'h07, 8'h09, 1'b0);
        queue_request(21'h01234, 8'h07, 8'h09, 1'b1);
        queue_request(21'h01234, 8'h07, 8'h09, 1'b1);
        // A second copy of a key must still hit the lowest entry.
        queue_request(21'h0, 8'h00, 8'h00, 1'b0);
        queue_request(21'h0, 8'h00, 8'h00, 1'b1);
        queue_request(CODE_MAX, 8'hFF, 8'hFF, 1'b0);
        queue_request(21'h1, 8'h00, 8'h00, 1'b1);
        queue_request(21'h0, 8'h01, 8'h00, 1'b1);
        queue_request(21'h0, 8'h00, 8'h01, 1'b1);
        queue_request(21'h0AAAAA, 8'hAA, 8'h55, 1'b1);
        queue_request(21'h155555, 8'h55, 8'hAA, 1'b1);
        queue_request(21'h0AAAAA, 8'hAA, 8'h55, 1'b1);
        queue_request(21'h155555, 8'h55, 8'hAA, 1'b0);
        queue_request(21'h155555, 8'h55, 8'hAA, 1'b1);
        queue_request(21'h100000, 8'h80, 8'h80, 1'b1);
        queue_request(21'h100000, 8'h80, 8'h80, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            span = (sent_keys.size() < 160) ? sent_keys.size() : 160;
            pick = sent_keys.size() - 1 - $urandom_range(0, span - 1);
            sel  = $urandom_range(0, 99);
            if (sel < 45) begin
                queue_request(sent_keys[pick].code, sent_keys[pick].width,
                              sent_keys[pick].height, 1'b1);
            end else if (sel < 80) begin
                key = random_glyph_key();
                queue_request(key.code, key.width, key.height, 1'b1);
            end else if (sel < 90) begin
                queue_request(sent_keys[pick].code, sent_keys[pick].width,
                              sent_keys[pick].height, 1'b0);
            end else begin
                key = random_glyph_key();
                queue_request(key.code, key.width, key.height, 1'b0);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(pending_reqs.size() == 0 && !s_tvalid && expected_results.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(negedge aclk);

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", expected_results.size());
            $display("FAILURE");
            $finish;
        end else begin
            repeat (TAIL_CYCLES) @(negedge aclk);
            $display("Covered %0d requests: %0d hits, %0d full-opacity misses, %0d partial writes.",
                     accepted_in, hit_count, miss_count, partial_count);
            $display("The fill pointer wrapped %0d times; %0d errors were found.",
                     wrap_count, errors);
            if (errors == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
            $finish;
        end
    end

endmodule
